FILE: rtl/fdm_pkg.sv
// Package for the fault debounce monitor.
// Holds the transfer payload types, command codes and status codes.
// No dependencies.
package fdm_pkg;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_POLL     = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FAIL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  channel;
    logic [15:0] entry_threshold;
    logic        entry_level;
    logic [15:0] error_flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] entry_index;
    logic       fault_active;
    logic       severity;
    logic       raised;
    logic       cleared;
    logic       last;
  } out_item_t;

endpackage

FILE: rtl/fault_debounce_monitor_unit.sv
// Fault debounce monitor: a table of fault entries with debounce counters. Depends on fdm_pkg.
// Register and query results are registered and appear the cycle after the input
// transfer; unused commands give no result.
// A poll walks the N registered entries in order: one shared counter update and threshold
// compare unit visits one entry per cycle while the output is not stalled.
// Reset (rst_n, synchronous, active low) empties the table and clears the sequencer.
module fault_debounce_monitor_unit #(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fdm_pkg::in_item_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fdm_pkg::out_item_t out_data
);

  localparam int CAP   = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
  localparam int IW    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int TW    = $clog2(CAP + 1);
  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [15:0]          thr_mem [CAP];
  logic                 lvl_mem [CAP];
  logic [COUNT_WIDTH-1:0] cnt_mem [CAP];
  logic                 act_mem [CAP];

  logic                 state_r, state_nxt;
  logic [TW-1:0]        total_r, total_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [CAP-1:0]       flags_r, flags_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fdm_pkg::out_item_t   out_data_r, out_data_nxt;

  logic                 out_free;
  logic                 in_xfer;
  logic                 reg_we;
  logic [IW-1:0]        reg_idx;
  logic                 upd_we;
  logic [IW-1:0]        rd_idx;
  logic [15:0]          rd_thr;
  logic                 rd_lvl;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic                 rd_act;
  logic                 fail;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                 cnt_ge;
  logic                 raise_ev;
  logic                 clear_ev;
  logic                 act_mid;
  logic                 act_new;
  logic                 walk_last;
  logic                 query_hit;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign reg_idx   = total_r[IW-1:0];
  assign rd_idx    = (state_r == ST_WALK) ? idx_r : in_data.channel[IW-1:0];
  assign rd_thr    = thr_mem[rd_idx];
  assign rd_lvl    = lvl_mem[rd_idx];
  assign rd_cnt    = cnt_mem[rd_idx];
  assign rd_act    = act_mem[rd_idx];

  // Shared debounce unit: saturating count, threshold compare, event flags.
  always_comb begin
    fail    = flags_r[idx_r];
    cnt_new = '0;
    if (fail) begin
      cnt_new = rd_cnt;
      if ((CMP_W'(rd_cnt) < CMP_W'(rd_thr)) && (rd_cnt != {COUNT_WIDTH{1'b1}})) begin
        cnt_new = rd_cnt + 1'b1;
      end
    end
    cnt_ge   = CMP_W'(cnt_new) >= CMP_W'(rd_thr);
    raise_ev = cnt_ge && !rd_act;
    act_mid  = rd_act || raise_ev;
    clear_ev = (cnt_new == '0) && act_mid;
    act_new  = act_mid && !clear_ev;
  end

  assign walk_last = (TW'(idx_r) + 1'b1) == total_r;
  assign query_hit = 5'(in_data.channel) < 5'(total_r);

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    reg_we        = 1'b0;
    upd_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.command)
            fdm_pkg::CMD_REGISTER: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.last = 1'b1;
              if (total_r >= TW'(CAP)) begin
                out_data_nxt.status = fdm_pkg::STATUS_FAIL;
              end else begin
                reg_we    = 1'b1;
                total_nxt = total_r + 1'b1;
                out_data_nxt.status      = fdm_pkg::STATUS_OK;
                out_data_nxt.entry_index = 4'(reg_idx);
                out_data_nxt.severity    = in_data.entry_level;
              end
            end
            fdm_pkg::CMD_POLL: begin
              if (total_r == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
                out_data_nxt.status = fdm_pkg::STATUS_EMPTY;
                out_data_nxt.last   = 1'b1;
              end else begin
                flags_nxt = in_data.error_flags[CAP-1:0];
                idx_nxt   = '0;
                state_nxt = ST_WALK;
              end
            end
            fdm_pkg::CMD_QUERY: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.entry_index = in_data.channel;
              out_data_nxt.last        = 1'b1;
              if (query_hit) begin
                out_data_nxt.status       = fdm_pkg::STATUS_OK;
                out_data_nxt.fault_active = rd_act;
                out_data_nxt.severity     = rd_lvl;
              end else begin
                out_data_nxt.status = fdm_pkg::STATUS_FAIL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          upd_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt.status       = fdm_pkg::STATUS_OK;
          out_data_nxt.entry_index  = 4'(idx_r);
          out_data_nxt.fault_active = act_new;
          out_data_nxt.severity     = rd_lvl;
          out_data_nxt.raised       = raise_ev;
          out_data_nxt.cleared      = clear_ev;
          out_data_nxt.last         = walk_last;
          if (walk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (reg_we) begin
      thr_mem[reg_idx] <= in_data.entry_threshold;
      lvl_mem[reg_idx] <= in_data.entry_level;
      cnt_mem[reg_idx] <= '0;
      act_mem[reg_idx] <= 1'b0;
    end else if (upd_we) begin
      cnt_mem[idx_r] <= cnt_new;
      act_mem[idx_r] <= act_new;
    end
  end

`ifndef SYNTHESIS
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(CAP))
    else $error("entry count exceeds table capacity");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (TW'(idx_r) < total_r))
    else $error("poll walk index beyond registered entries");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && out_free && walk_last) |=> (state_r == ST_IDLE))
    else $error("poll walk did not end after its last entry");

  a_no_transfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !in_xfer)
    else $error("input transfer during poll walk");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == fdm_pkg::STATUS_EMPTY) |-> out_data_r.last)
    else $error("empty poll result not marked last");
`endif

endmodule
